@@ rtl/core/uft_pkg.sv @@
// ----------------------------------------------------------------------------
// uft_pkg
// Shared types and byte encoder for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uft_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAddrW = $clog2(QDepth);

    localparam logic [15:0] HighLo   = 16'hD800;
    localparam logic [15:0] HighHi   = 16'hDBFF;
    localparam logic [15:0] LowLo    = 16'hDC00;
    localparam logic [15:0] LowHi    = 16'hDFFF;
    localparam logic [20:0] SuppBase = 21'h10000;
    localparam logic [20:0] ReplCp   = 21'h00FFFD;
    localparam logic [2:0]  ReplLen  = 3'd3;

    typedef struct packed {
        logic        rep;
        logic        term;
        logic [2:0]  len;
        logic [20:0] cp;
    } t_cmd;

    function automatic logic [7:0] uft_byte(
        input logic [20:0] cp,
        input logic [2:0]  len,
        input logic [1:0]  k
    );
        logic [7:0] b;
        b = 8'h00;
        case (len)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/uft_front.sv @@
// ----------------------------------------------------------------------------
// uft_front
// Accept code units, pair surrogates and queue byte-run requests; a held high surrogate queues none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uft_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [15:0]   i_code_unit,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_wr_en,
    output uft_pkg::t_cmd o_wr_cmd
);

    logic          r_pend_valid;
    logic [9:0]    r_pend_high;
    logic          n_pend_valid;
    logic [9:0]    n_pend_high;
    logic          acc;
    logic          is_low;
    logic          is_high;
    uft_pkg::t_cmd cmd;

    assign acc     = i_push && !i_q_full;
    assign is_low  = (i_code_unit >= uft_pkg::LowLo) && (i_code_unit <= uft_pkg::LowHi);
    assign is_high = (i_code_unit >= uft_pkg::HighLo) && (i_code_unit <= uft_pkg::HighHi);

    always_comb begin
        cmd          = '0;
        n_pend_valid = r_pend_valid;
        n_pend_high  = r_pend_high;
        if (r_pend_valid && is_low) begin
            cmd.len      = 3'd4;
            cmd.cp       = uft_pkg::SuppBase | {1'b0, r_pend_high, i_code_unit[9:0]};
            n_pend_valid = 1'b0;
            n_pend_high  = '0;
        end else begin
            cmd.rep      = r_pend_valid;
            n_pend_valid = 1'b0;
            n_pend_high  = '0;
            if (i_code_unit == 16'd0) begin
                cmd.term = 1'b1;
                cmd.len  = 3'd1;
            end else if (is_high) begin
                n_pend_valid = 1'b1;
                n_pend_high  = i_code_unit[9:0];
            end else if (is_low) begin
                cmd.len = uft_pkg::ReplLen;
                cmd.cp  = uft_pkg::ReplCp;
            end else begin
                cmd.cp = {5'd0, i_code_unit};
                if (i_code_unit < 16'h0080) begin
                    cmd.len = 3'd1;
                end else if (i_code_unit < 16'h0800) begin
                    cmd.len = 3'd2;
                end else begin
                    cmd.len = 3'd3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_high  <= '0;
        end else if (acc) begin
            r_pend_valid <= n_pend_valid;
            r_pend_high  <= n_pend_high;
        end
    end

    assign o_full   = i_q_full;
    assign o_wr_en  = acc && (cmd.rep || (cmd.len != 3'd0));
    assign o_wr_cmd = cmd;

endmodule

@@ rtl/core/uft_queue.sv @@
// ----------------------------------------------------------------------------
// uft_queue
// Short request queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uft_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  uft_pkg::t_cmd i_wr_cmd,
    input  logic          i_rd_en,
    output uft_pkg::t_cmd o_rd_cmd,
    output logic          o_full,
    output logic          o_empty
);

    uft_pkg::t_cmd                r_mem [uft_pkg::QDepth];
    logic [uft_pkg::QAddrW-1:0]   r_wr_ptr;
    logic [uft_pkg::QAddrW-1:0]   r_rd_ptr;
    logic [uft_pkg::QAddrW:0]     r_count;
    logic                         wr;
    logic                         rd;

    assign o_full   = (r_count == (uft_pkg::QAddrW+1)'(uft_pkg::QDepth));
    assign o_empty  = (r_count == '0);
    assign wr       = i_wr_en && !o_full;
    assign rd       = i_rd_en && !o_empty;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/uft_back.sv @@
// ----------------------------------------------------------------------------
// uft_back
// Serialize queued requests into UTF-8 bytes, one byte per cycle while pop drains the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uft_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uft_pkg::t_cmd i_cmd,
    input  logic          i_q_empty,
    output logic          o_rd_en,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_is_terminator,
    output logic          o_last_of_run
);

    logic          r_busy;
    uft_pkg::t_cmd r_cmd;
    logic [2:0]    r_idx;
    logic [2:0]    r_total;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_term;
    logic          r_out_last;

    logic          advance;
    logic          is_last;
    logic          take;
    logic          in_rep;
    logic [2:0]    k;
    logic [7:0]    n_byte;
    logic          n_term;

    assign advance = !r_out_valid || i_pop;
    assign is_last = (r_idx == r_total - 3'd1);
    assign take    = !i_q_empty && (!r_busy || (advance && is_last));
    assign o_rd_en = take;

    always_comb begin
        in_rep = r_cmd.rep && (r_idx < uft_pkg::ReplLen);
        k      = r_cmd.rep ? (r_idx - uft_pkg::ReplLen) : r_idx;
        n_term = 1'b0;
        if (in_rep) begin
            n_byte = uft_pkg::uft_byte(uft_pkg::ReplCp, uft_pkg::ReplLen, r_idx[1:0]);
        end else if (r_cmd.term) begin
            n_byte = 8'h00;
            n_term = 1'b1;
        end else begin
            n_byte = uft_pkg::uft_byte(r_cmd.cp, r_cmd.len, k[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (take) begin
                r_busy  <= 1'b1;
                r_cmd   <= i_cmd;
                r_idx   <= '0;
                r_total <= (i_cmd.rep ? uft_pkg::ReplLen : 3'd0) + i_cmd.len;
            end else if (r_busy && advance) begin
                r_idx <= r_idx + 3'd1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out_byte <= n_byte;
            r_out_term <= n_term;
            r_out_last <= is_last;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_is_terminator = r_out_term;
    assign o_last_of_run   = r_out_last;

endmodule

@@ rtl/core/utf16_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Path: a request passes the queue, the serializer register and the output register.
// Throughput: one byte per cycle at the output register while pop drains it; a BMP
// unit yields 1 to 3 bytes, a pair 4, a held high surrogate none, U+FFFD adds 3.
// Reset: synchronous; clears pending surrogate, request queue and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_code_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_is_terminator,
    output logic        o_last_of_run
);

    logic          q_full;
    logic          q_empty;
    logic          wr_en;
    logic          rd_en;
    uft_pkg::t_cmd wr_cmd;
    uft_pkg::t_cmd rd_cmd;

    uft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_code_unit (i_code_unit),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_wr_en     (wr_en),
        .o_wr_cmd    (wr_cmd)
    );

    uft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_cmd (wr_cmd),
        .i_rd_en  (rd_en),
        .o_rd_cmd (rd_cmd),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    uft_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (rd_cmd),
        .i_q_empty       (q_empty),
        .o_rd_en         (rd_en),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_is_terminator (o_is_terminator),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

@@ rtl/core/uft_checker.sv @@
// ----------------------------------------------------------------------------
// uft_checker
// Port-level checks for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic        o_is_terminator,
    input logic        o_last_of_run
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("outputs not cleared after reset");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_terminator) |-> (o_out_byte == 8'h00 && o_last_of_run))
        else $error("terminator byte malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("stalled result changed");

    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_byte[7:6] == 2'b11) |-> !o_last_of_run)
        else $error("lead byte ends a run");

endmodule

bind utf16_to_utf8_transcoder uft_checker u_uft_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_out_byte      (o_out_byte),
    .o_is_terminator (o_is_terminator),
    .o_last_of_run   (o_last_of_run)
);
